// File: design/ngsv_pkg.sv
package ngsv_pkg;

  localparam logic [3:0] PH_PREFIX = 4'd0;
  localparam logic [3:0] PH_NAME   = 4'd1;
  localparam logic [3:0] PH_F1_WS  = 4'd2;
  localparam logic [3:0] PH_F1_DIG = 4'd4;
  localparam logic [3:0] PH_F2_WS  = 4'd5;
  localparam logic [3:0] PH_F2_DIG = 4'd7;
  localparam logic [3:0] PH_F3_WS  = 4'd8;
  localparam logic [3:0] PH_F3_DIG = 4'd10;
  localparam logic [3:0] PH_DONE   = 4'd11;
  localparam logic [3:0] PH_FAIL   = 4'd12;

  localparam logic [1:0] SUB_WS  = 2'd0;
  localparam logic [1:0] SUB_SGN = 2'd1;

  localparam logic [2:0] PREFIX_LEN = 3'd6;

  typedef struct packed {
    logic [2:0] byte_pos;
    logic       prefix_good;
    logic [3:0] parse_phase;
    logic [7:0] field_accum;
    logic       minus_seen;
    logic       sentence_ended;
  } state_t;

  localparam state_t STATE_RST = '{
    byte_pos:       3'd0,
    prefix_good:    1'b1,
    parse_phase:    PH_PREFIX,
    field_accum:    8'd0,
    minus_seen:     1'b0,
    sentence_ended: 1'b0
  };

  typedef struct packed {
    logic [7:0] sat_count;
    logic       fields_ok;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic prefix_byte_ok(input logic [2:0] pos, input logic [7:0] c);
    logic ok;
    case (pos)
      3'd0: ok = (c == 8'h24);
      3'd1: ok = (c == 8'h47);
      3'd2: ok = (c == 8'h50) || (c == 8'h4C) || (c == 8'h41) ||
                 (c == 8'h42) || (c == 8'h4E);
      3'd3: ok = (c == 8'h47);
      3'd4: ok = (c == 8'h53);
      3'd5: ok = (c == 8'h56);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// File: design/ngsv_if.sv
interface ngsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink (input valid, input char_in, input last, output ready);
endinterface

interface ngsv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sat_count;
  logic       fields_ok;

  modport source (output valid, output sat_count, output fields_ok, input ready);
  modport sink (input valid, input sat_count, input fields_ok, output ready);
endinterface

// File: design/ngsv_step.sv
module ngsv_step
  import ngsv_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] char_i,
  output state_t     state_o,
  output result_t    result_o
);

  logic [3:0] base;
  logic       third;
  logic       in_field;

  always_comb begin
    base     = PH_F1_WS;
    third    = 1'b0;
    in_field = 1'b0;
    if (state_i.parse_phase >= PH_F1_WS && state_i.parse_phase <= PH_F1_DIG) begin
      in_field = 1'b1;
    end else if (state_i.parse_phase >= PH_F2_WS && state_i.parse_phase <= PH_F2_DIG) begin
      base     = PH_F2_WS;
      in_field = 1'b1;
    end else if (state_i.parse_phase >= PH_F3_WS && state_i.parse_phase <= PH_F3_DIG) begin
      base     = PH_F3_WS;
      third    = 1'b1;
      in_field = 1'b1;
    end
  end

  always_comb begin
    state_t     s;
    logic [1:0] sub;
    logic [3:0] diff;
    logic       take_digit;
    s          = state_i;
    diff       = state_i.parse_phase - base;
    sub        = diff[1:0];
    take_digit = 1'b0;
    if (!state_i.sentence_ended) begin
      if (char_i == 8'h00) begin
        s.sentence_ended = 1'b1;
      end else if (state_i.parse_phase == PH_PREFIX) begin
        if (!prefix_byte_ok(state_i.byte_pos, char_i)) begin
          s.prefix_good = 1'b0;
          s.parse_phase = PH_FAIL;
        end else begin
          s.byte_pos = state_i.byte_pos + 3'd1;
          if (s.byte_pos >= PREFIX_LEN) begin
            s.parse_phase = PH_NAME;
          end
        end
      end else if (state_i.parse_phase == PH_NAME) begin
        if (char_i == 8'h2C) begin
          s.parse_phase = PH_F1_WS;
        end
      end else if (in_field) begin
        if (sub == SUB_WS && !is_ws(char_i)) begin
          s.minus_seen = 1'b0;
          if (third) begin
            s.field_accum = 8'd0;
          end
          if (char_i == 8'h2B || char_i == 8'h2D) begin
            s.minus_seen  = (char_i == 8'h2D);
            s.parse_phase = base + 4'd1;
          end else begin
            sub = SUB_SGN;
          end
        end
        if (sub == SUB_SGN) begin
          if (!is_digit(char_i)) begin
            s.parse_phase = PH_FAIL;
          end else begin
            s.parse_phase = base + 4'd2;
            take_digit    = 1'b1;
          end
        end else if (sub != SUB_WS) begin
          if (is_digit(char_i)) begin
            take_digit = 1'b1;
          end else if (third) begin
            s.parse_phase = PH_DONE;
          end else if (char_i == 8'h2C) begin
            s.parse_phase = base + 4'd3;
          end else begin
            s.parse_phase = PH_FAIL;
          end
        end
        if (take_digit && third) begin
          s.field_accum = {s.field_accum[4:0], 3'b000} + {s.field_accum[6:0], 1'b0} +
                          (char_i - 8'h30);
        end
      end
    end
    state_o = s;
  end

  always_comb begin
    logic ok;
    ok = state_o.prefix_good &&
         (state_o.parse_phase == PH_F3_DIG || state_o.parse_phase == PH_DONE);
    result_o.fields_ok = ok;
    if (!ok) begin
      result_o.sat_count = 8'd0;
    end else if (state_o.minus_seen) begin
      result_o.sat_count = 8'd0 - state_o.field_accum;
    end else begin
      result_o.sat_count = state_o.field_accum;
    end
  end

endmodule

// File: design/nmea_gsv_sat_count_parser_top.sv
// Result path: a sentence's last byte sits in the input register, then the
// result register loads from it; that load waits while the previous result
// is stalled. Throughput: one byte per cycle, but a last byte waits while a
// result is stalled; parser state updates once per byte.
// Reset: asynchronous, active low; clears both valid flags and the parser state.
// A sentence's state returns to its reset value after its last byte.
module nmea_gsv_sat_count_parser_top
  import ngsv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ngsv_in_if.sink           in_i,
  ngsv_out_if.source        out_o
);

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  state_t     state_q;
  state_t     state_d;
  result_t    result_d;
  logic       out_valid_q;
  result_t    result_q;
  logic       advance;

  assign advance     = in_valid_q && (!last_q || !out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.char_in;
      last_q <= in_i.last;
    end
  end

  ngsv_step u_step (
    .state_i  (state_q),
    .char_i   (char_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (advance) begin
      state_q <= last_q ? STATE_RST : state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.sat_count = result_q.sat_count;
  assign out_o.fields_ok = result_q.fields_ok;

endmodule

// File: design/ngsv_chk.sv
module ngsv_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] sat_count_i,
  input logic       fields_ok_i
);

  a_reset_no_out: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_stall_only_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a stalled result");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !fields_ok_i) |-> (sat_count_i == 8'd0))
    else $error("failed sentence with nonzero count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(sat_count_i) &&
                                       $stable(fields_ok_i)))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_i) |=> in_valid_i)
    else $error("input item withdrawn while stalled");

endmodule

bind nmea_gsv_sat_count_parser_top ngsv_chk u_ngsv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sat_count_i (out_o.sat_count),
  .fields_ok_i (out_o.fields_ok)
);
